[rtl/core/arpc_pkg.sv]
// Shared types and constants for the ARP cache with aging.
// Used by the controller, the datapath and the top level. No dependencies.
package arpc_pkg;

   localparam int ENTRIES_DEFAULT = 16;

   localparam int OP_W        = 2;
   localparam int IP_W        = 32;
   localparam int MAC_W       = 48;
   localparam int STAMP_W     = 16;
   localparam int TIMEOUT_W   = 15;
   localparam int COUNT_OUT_W = 5;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 15'd60;

   // Operation codes; code 3 is unused and leaves the state alone
   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_TICK   = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE,
      ST_DONE
   } state_type;

   // One table slot as stored in the entry RAM
   typedef struct packed {
      logic               valid;
      logic [IP_W-1:0]    ip;
      logic [MAC_W-1:0]   mac;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Controller to datapath
   typedef struct packed {
      logic accept;      // request transfer this cycle
      logic clr_write;   // clearing pass: invalidate slot at walk index
      logic scan_read;   // walk: read slot at walk index
      logic commit;      // add: write the chosen slot
      logic rsp_load;    // load the response register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic   idx_last;
      logic   rsp_busy;
      op_type op;
   } sts_type;

endpackage

[rtl/core/arpc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module arpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

[rtl/core/arpc_ctrl.sv]
// Sequencer for the ARP cache: clearing pass, table walk, write-back, response.
// Depends on arpc_pkg.
module arpc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  arpc_pkg::sts_type sts,
   output arpc_pkg::cmd_type cmd
);

   import arpc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.idx_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.idx_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = (sts.op == OP_ADD) ? ST_WRITE : ST_DONE;
         end
         ST_WRITE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!sts.rsp_busy) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_CLEAR: cmd.clr_write = 1'b1;
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_SCAN:  cmd.scan_read = 1'b1;
         ST_DRAIN: ;
         ST_WRITE: cmd.commit = 1'b1;
         ST_DONE:  cmd.rsp_load = !sts.rsp_busy;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/arpc_dp.sv]
// Datapath for the ARP cache: entry RAM, walk index, match/free/expiry
// tracking, second counter, occupancy count, timeout register, response.
// Depends on arpc_pkg and arpc_ram.
module arpc_dp #(
   parameter int ENTRIES = arpc_pkg::ENTRIES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  arpc_pkg::cmd_type                cmd,
   output arpc_pkg::sts_type                sts,
   input  logic [arpc_pkg::OP_W-1:0]        req_operation,
   input  logic [arpc_pkg::IP_W-1:0]        req_ip_address,
   input  logic [arpc_pkg::MAC_W-1:0]       req_mac_address,
   input  logic                             csr_write_enable,
   input  logic [arpc_pkg::TIMEOUT_W-1:0]   csr_write_data,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic                             rsp_hit,
   output logic [arpc_pkg::MAC_W-1:0]       rsp_found_mac,
   output logic [arpc_pkg::COUNT_OUT_W-1:0] rsp_entry_count,
   output logic                             rsp_status
);

   import arpc_pkg::*;

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int CLOG_N = $clog2(ENTRIES + 1);
   localparam int CNT_W  = (CLOG_N > COUNT_OUT_W) ? CLOG_N : COUNT_OUT_W;

   logic [IDX_W-1:0]     idx_ff, idx_in;
   op_type               op_ff;
   logic [IP_W-1:0]      ip_ff;
   logic [MAC_W-1:0]     mac_ff;
   logic [STAMP_W-1:0]   now_ff, now_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic                 chk_vld_ff;
   logic [IDX_W-1:0]     chk_idx_ff;
   logic                 hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]     hit_idx_ff;
   logic [MAC_W-1:0]     hit_mac_ff;
   logic                 free_found_ff, free_found_in;
   logic [IDX_W-1:0]     free_idx_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff;
   logic [MAC_W-1:0]     rsp_mac_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;
   logic                 rsp_status_ff;

   logic                 idx_last;
   logic [ENTRY_W-1:0]   rd_data;
   entry_type            rd_entry;
   logic [STAMP_W-1:0]   age;
   logic                 match;
   logic                 free_seen;
   logic                 expire;
   logic                 insert_new;
   logic                 lookup_hit;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   entry_type            wr_entry;

   arpc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.scan_read),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign idx_last = (idx_ff == IDX_W'(ENTRIES - 1));
   assign rd_entry = rd_data;

   // Read data is registered, so it lags the walk index by one register
   assign age       = now_ff - rd_entry.stamp;
   assign match     = chk_vld_ff && rd_entry.valid && (rd_entry.ip == ip_ff);
   assign free_seen = chk_vld_ff && !rd_entry.valid;
   assign expire    = chk_vld_ff && (op_ff == OP_TICK) && rd_entry.valid
                      && (age >= STAMP_W'(timeout_ff));
   assign insert_new = cmd.commit && !hit_found_ff && free_found_ff;
   assign lookup_hit = (op_ff == OP_LOOKUP) && hit_found_ff;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.accept) begin
         idx_in = '0;
      end else if (cmd.clr_write || cmd.scan_read) begin
         idx_in = idx_last ? '0 : idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      hit_found_in  = cmd.accept ? 1'b0 : (hit_found_ff | match);
      free_found_in = cmd.accept ? 1'b0 : (free_found_ff | free_seen);
      now_in        = now_ff;
      if (cmd.accept && (req_operation == OP_TICK)) begin
         now_in = now_ff + STAMP_W'(1);
      end
      timeout_in = csr_write_enable ? csr_write_data : timeout_ff;
   end

   // An expiry and an insert never fall in the same cycle
   always_comb begin
      count_in = count_ff;
      if (expire) begin
         count_in = count_ff - CNT_W'(1);
      end else if (insert_new) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_entry = '0;
      priority if (cmd.clr_write) begin
         wr_en = 1'b1;
      end else if (expire) begin
         wr_en   = 1'b1;
         wr_addr = chk_idx_ff;
      end else if (cmd.commit && (hit_found_ff || free_found_ff)) begin
         wr_en          = 1'b1;
         wr_addr        = hit_found_ff ? hit_idx_ff : free_idx_ff;
         wr_entry.valid = 1'b1;
         wr_entry.ip    = ip_ff;
         wr_entry.mac   = mac_ff;
         wr_entry.stamp = now_ff;
      end else begin
         wr_en = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         now_ff        <= '0;
         count_ff      <= '0;
         timeout_ff    <= TIMEOUT_RESET;
         chk_vld_ff    <= 1'b0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         now_ff        <= now_in;
         count_ff      <= count_in;
         timeout_ff    <= timeout_in;
         chk_vld_ff    <= cmd.scan_read;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= idx_ff;
      if (cmd.accept) begin
         op_ff  <= op_type'(req_operation);
         ip_ff  <= req_ip_address;
         mac_ff <= req_mac_address;
      end
      if (match && !hit_found_ff) begin
         hit_idx_ff <= chk_idx_ff;
         hit_mac_ff <= rd_entry.mac;
      end
      if (free_seen && !free_found_ff) begin
         free_idx_ff <= chk_idx_ff;
      end
      if (cmd.rsp_load) begin
         rsp_hit_ff    <= lookup_hit;
         rsp_mac_ff    <= lookup_hit ? hit_mac_ff : '0;
         rsp_count_ff  <= count_ff[COUNT_OUT_W-1:0];
         rsp_status_ff <= (op_ff == OP_ADD) && !hit_found_ff && !free_found_ff;
      end
   end

   assign sts.idx_last = idx_last;
   assign sts.rsp_busy = rsp_valid_ff && !rsp_ready;
   assign sts.op       = op_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_found_mac   = rsp_mac_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

[rtl/core/arp_cache_with_aging.sv]
// ARP cache with aging: IPv4 to MAC table of ENTRIES slots in one RAM.
// Every request walks the whole RAM, one slot a cycle through its read port;
// an add then writes back its slot. The next request is taken once the
// response is loaded, which waits for the previous response to be accepted.
// Sync reset; afterwards a clearing pass invalidates the RAM with req_ready
// low. Timeout resets to 60 and may be written at any time.
module arp_cache_with_aging #(
   parameter int ENTRIES = arpc_pkg::ENTRIES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [arpc_pkg::OP_W-1:0]        req_operation,
   input  logic [arpc_pkg::IP_W-1:0]        req_ip_address,
   input  logic [arpc_pkg::MAC_W-1:0]       req_mac_address,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_hit,
   output logic [arpc_pkg::MAC_W-1:0]       rsp_found_mac,
   output logic [arpc_pkg::COUNT_OUT_W-1:0] rsp_entry_count,
   output logic                             rsp_status,
   input  logic                             csr_write_enable,
   input  logic [arpc_pkg::TIMEOUT_W-1:0]   csr_write_data
);

   import arpc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   arpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   arpc_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_operation    (req_operation),
      .req_ip_address   (req_ip_address),
      .req_mac_address  (req_mac_address),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_found_mac    (rsp_found_mac),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_status       (rsp_status)
   );

endmodule

[test/tb.sv]
// Testbench for arp_cache_with_aging: directed and random add, lookup and tick
// transfers checked against a cycle-free table model held in a scoreboard class.
// Depends on arpc_pkg and the arp_cache_with_aging top level.

class arp_scoreboard #(int SLOTS = 16);

   typedef struct packed {
      logic                              hit;
      logic [arpc_pkg::MAC_W-1:0]        mac;
      logic [arpc_pkg::COUNT_OUT_W-1:0]  count;
      logic                              status;
   } reply_type;

   bit                            slot_used  [SLOTS];
   logic [arpc_pkg::IP_W-1:0]     slot_ip    [SLOTS];
   logic [arpc_pkg::MAC_W-1:0]    slot_mac   [SLOTS];
   logic [arpc_pkg::STAMP_W-1:0]  slot_stamp [SLOTS];
   logic [arpc_pkg::STAMP_W-1:0]  seconds;
   logic [arpc_pkg::TIMEOUT_W-1:0] timeout;
   int unsigned                   held;
   int unsigned                   mismatches;
   reply_type                     pending_replies [$];

   function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      seconds    = '0;
      timeout    = arpc_pkg::TIMEOUT_RESET;
      held       = 0;
      mismatches = 0;
   endfunction

   function int find_slot(logic [arpc_pkg::IP_W-1:0] ip);
      for (int i = 0; i < SLOTS; i++)
         if (slot_used[i] && slot_ip[i] == ip) return i;
      return -1;
   endfunction

   // Predict the response to one request transfer and queue it
   function void note_request(logic [arpc_pkg::OP_W-1:0] op,
                              logic [arpc_pkg::IP_W-1:0] ip,
                              logic [arpc_pkg::MAC_W-1:0] mac);
      reply_type                    r;
      int                           slot;
      logic [arpc_pkg::STAMP_W-1:0] age;
      r = '0;
      case (op)
         arpc_pkg::OP_ADD: begin
            slot = find_slot(ip);
            if (slot < 0) begin
               // new address goes to the lowest free slot
               for (int i = SLOTS - 1; i >= 0; i--)
                  if (!slot_used[i]) slot = i;
               if (slot >= 0) begin
                  slot_used[slot] = 1'b1;
                  slot_ip[slot]   = ip;
                  held++;
               end
            end
            if (slot >= 0) begin
               slot_mac[slot]   = mac;
               slot_stamp[slot] = seconds;
            end else begin
               r.status = 1'b1;
            end
         end
         arpc_pkg::OP_LOOKUP: begin
            slot = find_slot(ip);
            if (slot >= 0) begin
               r.hit = 1'b1;
               r.mac = slot_mac[slot];
            end
         end
         arpc_pkg::OP_TICK: begin
            seconds = seconds + 1'b1;
            for (int i = 0; i < SLOTS; i++) begin
               age = seconds - slot_stamp[i];
               if (slot_used[i] && age >= timeout) begin
                  slot_used[i] = 1'b0;
                  held--;
               end
            end
         end
         default: ;
      endcase
      r.count = arpc_pkg::COUNT_OUT_W'(held);
      pending_replies.insert(pending_replies.size(), r);
   endfunction

   function void check_response(logic hit, logic [arpc_pkg::MAC_W-1:0] mac,
                                logic [arpc_pkg::COUNT_OUT_W-1:0] count, logic status);
      reply_type want;
      if (pending_replies.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("response with nothing pending: hit=%0b mac=%h count=%0d status=%0b",
                     hit, mac, count, status);
         return;
      end
      want = pending_replies.pop_front();
      if (want.hit !== hit || want.mac !== mac || want.count !== count ||
          want.status !== status) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"mismatch: expected hit=%0b mac=%h count=%0d status=%0b, ",
                      "got hit=%0b mac=%h count=%0d status=%0b"},
                     want.hit, want.mac, want.count, want.status, hit, mac, count, status);
      end
   endfunction

endclass

module tb;

   import arpc_pkg::*;

   localparam int SLOTS = ENTRIES_DEFAULT;
   localparam int STALL_LIMIT = 5000;
   localparam int POOL_SIZE = 24;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 130;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [OP_W-1:0]        req_operation = '0;
   logic [IP_W-1:0]        req_ip_address = '0;
   logic [MAC_W-1:0]       req_mac_address = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_hit;
   logic [MAC_W-1:0]       rsp_found_mac;
   logic [COUNT_OUT_W-1:0] rsp_entry_count;
   logic                   rsp_status;
   logic                   csr_write_enable = 1'b0;
   logic [TIMEOUT_W-1:0]   csr_write_data = '0;

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned quiet_cycles = 0;

   arp_scoreboard #(SLOTS) board;

   arp_cache_with_aging #(.ENTRIES(SLOTS)) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_ip_address  (req_ip_address),
      .req_mac_address (req_mac_address),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_found_mac   (rsp_found_mac),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Response side: check each transfer, then pick ready for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_response(rsp_hit, rsp_found_mac, rsp_entry_count, rsp_status);
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_request(input logic [OP_W-1:0] op, input logic [IP_W-1:0] ip,
                               input logic [MAC_W-1:0] mac);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_ip_address  <= ip;
      req_mac_address <= mac;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(op, ip, mac);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (board.pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
      drain_responses();
      repeat (SLOTS + 4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.timeout = value;
   endtask

   task automatic run_phase(input int unsigned items, input logic [TIMEOUT_W-1:0] tmo);
      logic [IP_W-1:0]  pool [POOL_SIZE];
      logic [OP_W-1:0]  op;
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
      int unsigned      pick;
      write_timeout(tmo);
      // a pool a bit larger than the table gives hits, overwrites and full drops
      foreach (pool[i]) pool[i] = $urandom();
      for (int n = 0; n < items; n++) begin
         if (n == items / 2) drain_responses();
         pick = $urandom_range(99);
         if (pick < 35)      op = OP_ADD;
         else if (pick < 75) op = OP_LOOKUP;
         else if (pick < 95) op = OP_TICK;
         else                op = OP_UNUSED;
         ip  = ($urandom_range(9) == 0) ? $urandom() : pool[$urandom_range(POOL_SIZE - 1)];
         mac = {16'($urandom()), $urandom()};
         send_request(op, ip, mac);
      end
   endtask

   initial begin
      int unsigned          send_mode [4];
      int unsigned          recv_mode [4];
      logic [TIMEOUT_W-1:0] phase_timeout [PHASES];
      logic [TIMEOUT_W-1:0] tmo;
      send_mode     = '{0, 81, 0, 6};
      recv_mode     = '{0, 0, 81, 6};
      phase_timeout = '{15'd32767, 15'd4, 15'd0, 15'd2, 15'd1, 15'd7, 15'd60, 15'd300};
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, overwrite, unused code, full table, zero timeout
      send_request(OP_ADD, 32'h0000_0000, 48'h0000_0000_0000);
      send_request(OP_ADD, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      send_request(OP_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
      send_request(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0);
      send_request(OP_LOOKUP, 32'h1234_5678, 48'h0);
      send_request(OP_ADD, 32'hFFFF_FFFF, 48'hA5A5_5A5A_0F0F);
      send_request(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0);
      send_request(OP_UNUSED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      send_request(OP_TICK, 32'h0, 48'h0);
      for (int k = 0; k < SLOTS - 1; k++)
         send_request(OP_ADD, 32'h0A00_0000 + k, 48'h0200_0000_0000 + k);
      send_request(OP_LOOKUP, 32'h0A00_0003, 48'h0);
      write_timeout(15'd0);
      send_request(OP_TICK, 32'h0, 48'h0);
      send_request(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0);

      for (int p = 0; p < PHASES; p++) begin
         send_idle_pct  = send_mode[p % 4];
         recv_stall_pct = recv_mode[p % 4];
         tmo = (p == PHASES - 1) ? TIMEOUT_W'($urandom_range(32767)) : phase_timeout[p];
         run_phase(PHASE_ITEMS, tmo);
      end

      drain_responses();
      repeat (SLOTS + 8) @(posedge clock);
      if (board.mismatches == 0 && board.pending_replies.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[sim.f]
rtl/core/arpc_pkg.sv
rtl/core/arpc_ram.sv
rtl/core/arpc_ctrl.sv
rtl/core/arpc_dp.sv
rtl/core/arp_cache_with_aging.sv
test/tb.sv
